[rtl/cira_pkg.sv]
package cira_pkg;

  localparam int POOL_SLOTS_DEF = 64;

  localparam logic       CMD_ALLOC    = 1'b0;
  localparam logic       CMD_FREE     = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOSPACE   = 3'd1;
  localparam logic [2:0] ST_BADCOUNT  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_NOTALLOC  = 3'd4;

  localparam logic       REG_IRQ_BASE = 1'b0;
  localparam logic [9:0] IRQ_BASE_RST = 10'd32;

  typedef struct packed {
    logic        cmd;
    logic [6:0]  run_length;
    logic [10:0] irq_in;
  } in_t;

  typedef struct packed {
    logic [10:0] irq_number;
    logic [2:0]  status;
    logic        last;
  } out_t;

endpackage

[rtl/contiguous_irq_range_allocator.sv]
// A free transaction gives its one result, decided in the decode state and registered.
// An allocate transaction passes a decode state, a scan state that examines pool slots
// in turn (at most POOL_SLOTS) and then an emit state, results on consecutive cycles.
// Throughput: one request at a time; busy stays high until its final result is issued.
// The single slot scanner (one bit test and run counter per cycle) sets the allocate time.
// Reset (synchronous, rst_n low) frees every slot and sets irq_base to 32.
module contiguous_irq_range_allocator #(
  parameter int POOL_SLOTS = cira_pkg::POOL_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cira_pkg::in_t  in_data,
  output logic           busy,
  output logic           out_valid,
  output cira_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import cira_pkg::*;

  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  in_t                   req_r, req_nxt;
  logic [SW-1:0]         scan_r, scan_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [SW-1:0]         emit_idx_r, emit_idx_nxt;
  logic [6:0]            emit_left_r, emit_left_nxt;
  logic [POOL_SLOTS-1:0] used_r, used_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_r, out_nxt;
  logic [9:0]            base_r;

  logic [10:0] slot_off;
  logic        below, above;
  logic [6:0]  cnt_inc;
  logic        slot_free;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IRQ_BASE) ? {22'd0, base_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= IRQ_BASE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IRQ_BASE)) begin
      base_r <= pwdata[9:0];
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slot_off  = req_r.irq_in - {1'b0, base_r};
  assign below     = (req_r.irq_in < {1'b0, base_r});
  assign above     = ({1'b0, req_r.irq_in} >= (12'(base_r) + 12'(POOL_SLOTS)));
  assign cnt_inc   = 7'(cnt_r) + 7'd1;
  assign slot_free = !used_r[scan_r];

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    cnt_nxt       = cnt_r;
    emit_idx_nxt  = emit_idx_r;
    emit_left_nxt = emit_left_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_data;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        if (req_r.cmd == CMD_FREE) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{irq_number: 11'd0, status: ST_OK, last: 1'b1};
          state_nxt     = S_IDLE;
          if (below || above) begin
            out_nxt.status = ST_RANGE;
          end else if (!used_r[slot_off[SW-1:0]]) begin
            out_nxt.status = ST_NOTALLOC;
          end else begin
            used_nxt[slot_off[SW-1:0]] = 1'b0;
          end
        end else if ((req_r.run_length == 7'd0) ||
                     (req_r.run_length > 7'(POOL_SLOTS))) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{irq_number: 11'd0, status: ST_BADCOUNT, last: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          scan_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // The first slot that completes a free run of the wanted length ends
        // the lowest such run.
        if (slot_free && (cnt_inc == req_r.run_length)) begin
          emit_idx_nxt  = scan_r - SW'(req_r.run_length) + SW'(1);
          emit_left_nxt = req_r.run_length;
          state_nxt     = S_EMIT;
        end else if (scan_r == SW'(POOL_SLOTS - 1)) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '{irq_number: 11'd0, status: ST_NOSPACE, last: 1'b1};
          state_nxt     = S_IDLE;
        end else begin
          cnt_nxt  = slot_free ? cnt_r + CW'(1) : '0;
          scan_nxt = scan_r + SW'(1);
        end
      end

      S_EMIT: begin
        used_nxt[emit_idx_r] = 1'b1;
        out_valid_nxt        = 1'b1;
        out_nxt.irq_number   = {1'b0, base_r} + 11'(emit_idx_r);
        out_nxt.status       = ST_OK;
        out_nxt.last         = (emit_left_r == 7'd1);
        emit_left_nxt        = emit_left_r - 7'd1;
        emit_idx_nxt         = emit_idx_r + SW'(1);
        if (emit_left_r == 7'd1) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      cnt_r       <= '0;
      emit_idx_r  <= '0;
      emit_left_r <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      cnt_r       <= cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      emit_left_r <= emit_left_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last)
    else $error("error result not marked last");

  a_emit_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("gap inside a run of allocated numbers");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result issued right after the final result");
`endif

endmodule
